// ===== hdl/indexed_list_insert_delete_unit_macros.svh =====
// Assertion macros shared by the indexed list unit.
`ifndef INDEXED_LIST_INSERT_DELETE_UNIT_MACROS_SVH
`define INDEXED_LIST_INSERT_DELETE_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define ILID_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off during reset.
`define ILID_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/ilid_pkg.sv =====
package ilid_pkg;

  localparam int unsigned DataW       = 32;
  localparam int unsigned OpW         = 3;
  localparam int unsigned PosW        = 7;
  localparam int unsigned StW         = 2;
  localparam int unsigned CntW        = 7;
  // Cell index width, enough for the largest supported capacity (1024)
  localparam int unsigned PosMaxW     = 10;
  localparam int unsigned CapacityDef = 64;

  typedef enum logic [OpW-1:0] {
    OpRead = 3'd0,
    OpHead = 3'd1,
    OpTail = 3'd2,
    OpAt   = 3'd3,
    OpDel  = 3'd4
  } op_e;

  typedef enum logic [StW-1:0] {
    StOk    = 2'd0,
    StRange = 2'd1,
    StFull  = 2'd2
  } status_e;

  // Broadcast from control to every cell
  typedef struct packed {
    logic               load;  // an item transfers this cycle
    logic               ins;   // insert that succeeds
    logic               del;   // delete that succeeds
    logic               rd;    // read that succeeds
    logic [PosMaxW-1:0] pos;   // target cell
  } cell_ctl_t;

endpackage

// ===== hdl/ilid_cell.sv =====
module ilid_cell #(
  parameter int unsigned Idx = 0
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  ilid_pkg::cell_ctl_t            ctl_i,
  input  logic [ilid_pkg::DataW-1:0]     data_i,
  input  logic [ilid_pkg::DataW-1:0]     left_i,
  input  logic [ilid_pkg::DataW-1:0]     right_i,
  output logic [ilid_pkg::DataW-1:0]     value_o,
  output logic [ilid_pkg::DataW-1:0]     tap_o
);
  import ilid_pkg::*;

  localparam logic [PosMaxW-1:0] MyIdx = PosMaxW'(Idx);

  logic [DataW-1:0] value_q, value_d;
  logic             value_en;
  logic [DataW-1:0] tap_q, tap_d;
  logic             tap_valid_q;

  // Shift/load selection for this entry
  always_comb begin
    value_d  = value_q;
    value_en = 1'b0;
    if (ctl_i.load && ctl_i.ins) begin
      if (MyIdx > ctl_i.pos) begin
        value_d  = left_i;
        value_en = 1'b1;
      end else if (MyIdx == ctl_i.pos) begin
        value_d  = data_i;
        value_en = 1'b1;
      end
    end else if (ctl_i.load && ctl_i.del && (MyIdx >= ctl_i.pos)) begin
      value_d  = right_i;
      value_en = 1'b1;
    end
  end

  // Entry storage, no reset
  always_ff @(posedge clk_i) begin
    if (value_en) begin
      value_q <= value_d;
    end
  end

  // Read tap: own value when addressed, else zero
  assign tap_d = (ctl_i.rd && (MyIdx == ctl_i.pos)) ? value_q : '0;

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      tap_q <= tap_d;
    end
  end

  // Tap only counts once it has been loaded
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tap_valid_q <= 1'b0;
    end else if (ctl_i.load) begin
      tap_valid_q <= 1'b1;
    end
  end

  assign value_o = value_q;
  assign tap_o   = tap_valid_q ? tap_q : '0;

endmodule

// ===== hdl/indexed_list_insert_delete_unit.sv =====
// Indexed list of up to CAPACITY signed 32-bit entries held in a row of cells,
// one entry per cell. Insert shifts every cell above the target up by one from
// its lower neighbor, delete shifts them down from the upper neighbor, both in
// the cycle the item transfers, so one item is accepted per cycle unless the
// output stalls. The addressed cell first registers its read tap, then the
// taps are OR-combined into the output register. Status gives ok, out of
// range, or full (insert into a full list is dropped); entry_count is the
// count after the operation, low 7 bits.
`include "indexed_list_insert_delete_unit_macros.svh"

module indexed_list_insert_delete_unit #(
  parameter int unsigned CAPACITY = ilid_pkg::CapacityDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [ilid_pkg::OpW-1:0]          opcode_i,
  input  logic [ilid_pkg::PosW-1:0]         position_i,
  input  logic signed [ilid_pkg::DataW-1:0] data_value_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [ilid_pkg::DataW-1:0] read_value_o,
  output logic [ilid_pkg::StW-1:0]          status_o,
  output logic [ilid_pkg::CntW-1:0]         entry_count_o
);
  import ilid_pkg::*;

  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned PW = (CW > PosW) ? CW : PosW;
  localparam logic [PW-1:0] CapFull = PW'(CAPACITY);

  logic [CW-1:0] count_q, count_d;
  logic          in_fire;
  logic          b_ready;

  // Stage A: taps live in the cells
  logic            a_valid_q;
  status_e         a_status_q, a_status_d;
  logic [CntW-1:0] a_count_q;

  // Stage B: output register
  logic              b_valid_q;
  logic [DataW-1:0]  b_value_q, b_value_d;
  status_e           b_status_q;
  logic [CntW-1:0]   b_count_q;

  logic [PW-1:0] cnt_ext, pos_ext, ins_pos;
  logic          ins_op, ins_ok, del_ok, rd_ok;
  cell_ctl_t     ctl;

  logic [DataW-1:0] val  [CAPACITY];
  logic [DataW-1:0] taps [CAPACITY];

  // Handshake
  assign b_ready    = !b_valid_q || out_ready_i;
  assign in_ready_o = !a_valid_q || b_ready;
  assign in_fire    = in_valid_i && in_ready_o;

  // Decode and range checks
  assign cnt_ext = PW'(count_q);
  assign pos_ext = PW'(position_i);

  always_comb begin
    ins_op     = 1'b0;
    ins_pos    = pos_ext;
    del_ok     = 1'b0;
    rd_ok      = 1'b0;
    a_status_d = StOk;
    unique case (opcode_i)
      OpRead: begin
        rd_ok = pos_ext < cnt_ext;
        if (!rd_ok) a_status_d = StRange;
      end
      OpHead: begin
        ins_op  = 1'b1;
        ins_pos = '0;
      end
      OpTail: begin
        ins_op  = 1'b1;
        ins_pos = cnt_ext;
      end
      OpAt: begin
        ins_op = 1'b1;
      end
      OpDel: begin
        del_ok = pos_ext < cnt_ext;
        if (!del_ok) a_status_d = StRange;
      end
      default: ;
    endcase
    ins_ok = 1'b0;
    if (ins_op) begin
      priority if (ins_pos > cnt_ext) begin
        a_status_d = StRange;
      end else if (cnt_ext >= CapFull) begin
        a_status_d = StFull;
      end else begin
        ins_ok = 1'b1;
      end
    end
  end

  // Next count
  always_comb begin
    count_d = count_q;
    if (in_fire && ins_ok) begin
      count_d = count_q + CW'(1);
    end else if (in_fire && del_ok) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  // Cell control broadcast
  always_comb begin
    ctl.load = in_fire;
    ctl.ins  = ins_ok;
    ctl.del  = del_ok;
    ctl.rd   = rd_ok;
    ctl.pos  = ins_ok ? PosMaxW'(ins_pos) : PosMaxW'(pos_ext);
  end

  // Row of cells
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DataW-1:0] left, right;
    if (i == 0) begin : g_first
      assign left = data_value_i;
    end else begin : g_mid_l
      assign left = val[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right = val[i];
    end else begin : g_mid_r
      assign right = val[i+1];
    end
    ilid_cell #(
      .Idx(i)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctl_i  (ctl),
      .data_i (data_value_i),
      .left_i (left),
      .right_i(right),
      .value_o(val[i]),
      .tap_o  (taps[i])
    );
  end

  // Stage A control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      a_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      a_status_q <= a_status_d;
      a_count_q  <= CntW'(count_d);
    end
  end

  // Combine taps: at most one is nonzero
  always_comb begin
    b_value_d = '0;
    for (int unsigned k = 0; k < CAPACITY; k++) begin
      b_value_d = b_value_d | taps[k];
    end
  end

  // Stage B output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (b_ready) begin
      b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_ready && a_valid_q) begin
      b_value_q  <= b_value_d;
      b_status_q <= a_status_q;
      b_count_q  <= a_count_q;
    end
  end

  assign out_valid_o   = b_valid_q;
  assign read_value_o  = b_value_q;
  assign status_o      = b_status_q;
  assign entry_count_o = b_count_q;

  // Checks
  `ILID_ASSERT_NOW(a_count_bound, 1'b1, PW'(count_q) <= CapFull, "count above capacity")
  `ILID_ASSERT_NEXT(a_count_hold, !in_fire, $stable(count_q), "count moved without transfer")
  `ILID_ASSERT_NOW(a_read_status, out_valid_o && (read_value_o != '0), status_o == StOk, "value on failed read")
  `ILID_ASSERT_NOW(a_full_count, out_valid_o && (status_o == StFull), entry_count_o == CntW'(CAPACITY), "full reported below capacity")

endmodule

// ===== verif/indexed_list_insert_delete_unit_tb.sv =====
module indexed_list_insert_delete_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ilid_pkg::*;

  localparam int unsigned Capacity = CapacityDef;
  localparam int unsigned MaxIdle = 11;
  localparam int unsigned RandomItems = 1500;
  localparam int unsigned PosTop = (1 << PosW) - 1;
  localparam logic [OpW-1:0] OpTop = '1;

  // Expected outcome of one transfer
  typedef struct {
    logic signed [DataW-1:0] read_value;
    status_e                 status;
    logic [CntW-1:0]         entry_count;
  } list_result_t;

  // Shadow copy of the list and the results still owed by the block
  class list_shadow;
    int unsigned             capacity;
    logic signed [DataW-1:0] entries[$];
    list_result_t            owed[$];
    int unsigned             mismatches;

    function new(int unsigned capacity_i);
      capacity = capacity_i;
      mismatches = 0;
    endfunction

    function int unsigned pending();
      return owed.size();
    endfunction

    // Insert before position at, range check ahead of the full check
    function status_e place(int unsigned at, logic signed [DataW-1:0] value);
      if (at > entries.size()) return StRange;
      if (entries.size() >= capacity) return StFull;
      entries.insert(at, value);
      return StOk;
    endfunction

    // Accepted input transfer: update the list, queue the result it owes
    function void apply_op(logic [OpW-1:0] op, logic [PosW-1:0] pos,
                           logic signed [DataW-1:0] value);
      list_result_t r;
      r.read_value = '0;
      r.status = StOk;
      case (op)
        OpRead: begin
          if (pos < entries.size()) r.read_value = entries[pos];
          else r.status = StRange;
        end
        OpHead: r.status = place(0, value);
        OpTail: r.status = place(entries.size(), value);
        OpAt:   r.status = place(pos, value);
        OpDel: begin
          if (pos < entries.size()) entries.delete(pos);
          else r.status = StRange;
        end
        default: ;  // undefined opcodes leave the list alone
      endcase
      r.entry_count = CntW'(entries.size());
      owed.push_back(r);
    endfunction

    // Accepted output transfer: compare against the oldest owed result
    function void compare_result(logic signed [DataW-1:0] read_value,
                                 logic [StW-1:0] status,
                                 logic [CntW-1:0] entry_count);
      list_result_t r;
      if (owed.size() == 0) begin
        $error("result with nothing owed: read_value %0d status %0d entry_count %0d",
               read_value, status, entry_count);
        mismatches++;
        return;
      end
      r = owed.pop_front();
      if (read_value !== r.read_value) begin
        $error("read_value: expected %0d, got %0d", r.read_value, read_value);
        mismatches++;
      end
      if (status !== r.status) begin
        $error("status: expected %0d, got %0d", r.status, status);
        mismatches++;
      end
      if (entry_count !== r.entry_count) begin
        $error("entry_count: expected %0d, got %0d", r.entry_count, entry_count);
        mismatches++;
      end
    endfunction
  endclass

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    in_valid_i = 1'b0;
  logic                    in_ready_o;
  logic [OpW-1:0]          opcode_i = '0;
  logic [PosW-1:0]         position_i = '0;
  logic signed [DataW-1:0] data_value_i = '0;
  logic                    out_valid_o;
  logic                    out_ready_i = 1'b0;
  logic signed [DataW-1:0] read_value_o;
  logic [StW-1:0]          status_o;
  logic [CntW-1:0]         entry_count_o;

  list_shadow  shadow = new(Capacity);
  bit          no_idle = 1'b0;      // both sides run back to back while set
  int unsigned list_len = 0;        // entry count as seen by the stimulus
  int unsigned items_sent = 0;      // defined opcodes only

  indexed_list_insert_delete_unit i_dut (.*);

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Both channels observed at the same edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) shadow.apply_op(opcode_i, position_i, data_value_i);
      if (out_valid_o && out_ready_i)
        shadow.compare_result(read_value_o, status_o, entry_count_o);
    end
  end

  // Drive one item and wait for its transfer
  task automatic push_op(input logic [OpW-1:0] op, input int unsigned pos,
                         input logic signed [DataW-1:0] value);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, MaxIdle);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    opcode_i <= op;
    position_i <= PosW'(pos);
    data_value_i <= value;
    do @(posedge clk_i); while (!in_ready_o);
    // keep the stimulus-side length in step
    case (op)
      OpHead, OpTail: if (list_len < Capacity) list_len++;
      OpAt: if (pos <= list_len && list_len < Capacity) list_len++;
      OpDel: if (pos < list_len) list_len--;
      default: ;
    endcase
    if (op <= OpDel) items_sent++;
  endtask

  function automatic logic signed [DataW-1:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'sh7fff_ffff;
      1: return 32'sh8000_0000;
      2: return '0;
      3: return -1;
      default: return $urandom;
    endcase
  endfunction

  function automatic int unsigned pick_in_list();
    return (list_len == 0) ? 0 : $urandom_range(0, list_len - 1);
  endfunction

  // Grow toward full, reads mixed in
  task automatic grow_item();
    case ($urandom_range(0, 4))
      0: push_op(OpRead, pick_in_list(), pick_value());
      1: push_op(OpHead, $urandom_range(0, PosTop), pick_value());
      2: push_op(OpTail, $urandom_range(0, PosTop), pick_value());
      default: push_op(OpAt, $urandom_range(0, list_len), pick_value());
    endcase
  endtask

  // Shrink toward empty, reads mixed in
  task automatic shrink_item();
    if ($urandom_range(0, 4) == 0) push_op(OpRead, pick_in_list(), pick_value());
    else push_op(OpDel, pick_in_list(), pick_value());
  endtask

  // Anything at all, mostly well formed
  task automatic mixed_item();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 8)
      push_op(OpW'($urandom_range(0, OpTop)), $urandom_range(0, PosTop), $urandom);
    else if (pick < 12)
      push_op(OpW'($urandom_range(OpDel + 1, OpTop)), $urandom_range(0, PosTop), $urandom);
    else if (pick < 35) push_op(OpRead, pick_in_list(), pick_value());
    else if (pick < 48) push_op(OpHead, $urandom_range(0, PosTop), pick_value());
    else if (pick < 60) push_op(OpTail, $urandom_range(0, PosTop), pick_value());
    else if (pick < 75) push_op(OpAt, $urandom_range(0, list_len), pick_value());
    else if (pick < 92) push_op(OpDel, pick_in_list(), pick_value());
    else begin
      // position at or past the end
      case ($urandom_range(0, 2))
        0: push_op(OpRead, $urandom_range(list_len, PosTop), pick_value());
        1: push_op(OpDel, $urandom_range(list_len, PosTop), pick_value());
        default: push_op(OpAt, $urandom_range(list_len + 1, PosTop), pick_value());
      endcase
    end
  endtask

  // Result side: random stall before each transfer
  initial begin
    int unsigned stall;
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, MaxIdle);
      if (stall != 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  initial begin
    int unsigned phase;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty list, extremes, every opcode, out-of-range positions
    push_op(OpRead, 0, '0);
    push_op(OpDel, 0, '0);
    push_op(OpAt, 1, 32'sd5);
    push_op(OpHead, PosTop, 32'sh7fff_ffff);
    push_op(OpTail, PosTop, 32'sh8000_0000);
    push_op(OpAt, 1, '0);
    push_op(OpAt, 3, -1);
    push_op(OpRead, 0, '0);
    push_op(OpRead, 3, '0);
    push_op(OpRead, 4, '0);
    push_op(OpRead, PosTop, -1);
    push_op(OpAt, PosTop, 32'sd9);
    push_op(OpDel, PosTop, '0);
    push_op(OpDel, 1, '0);
    push_op(OpDel, 2, '0);
    push_op(OpDel, 0, '0);
    for (int op = OpDel + 1; op <= OpTop; op++) push_op(OpW'(op), PosTop, $urandom);
    push_op(OpRead, 0, '0);
    push_op(OpDel, 0, '0);
    push_op(OpTail, 0, $urandom);
    push_op(OpHead, 0, $urandom);

    // Random phases: fill to full, drain to empty, or mixed traffic
    phase = 0;
    while (items_sent < RandomItems) begin
      no_idle = ($urandom_range(0, 5) == 0);
      case ((phase == 0) ? 0 : $urandom_range(0, 3))
        0: begin
          while (list_len < Capacity) grow_item();
          repeat ($urandom_range(4, 10)) begin
            case ($urandom_range(0, 5))
              0: push_op(OpHead, $urandom_range(0, PosTop), pick_value());
              1: push_op(OpTail, $urandom_range(0, PosTop), pick_value());
              2: push_op(OpAt, $urandom_range(0, Capacity), pick_value());
              3: push_op(OpAt, $urandom_range(Capacity + 1, PosTop), pick_value());
              4: push_op(OpRead, $urandom_range(Capacity - 1, PosTop), pick_value());
              default: push_op(OpDel, $urandom_range(Capacity, PosTop), pick_value());
            endcase
          end
        end
        1: begin
          while (list_len > 0) shrink_item();
          repeat ($urandom_range(2, 5)) mixed_item();
        end
        default: repeat ($urandom_range(20, 80)) mixed_item();
      endcase
      phase++;
    end
    no_idle = 1'b0;
    in_valid_i <= 1'b0;

    // let the monitor note the last input transfer before draining
    @(posedge clk_i);
    while (shadow.pending() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (shadow.mismatches == 0 && shadow.pending() == 0) begin
      $display("** indexed_list_insert_delete_unit: PASSED **");
    end else begin
      $display("** indexed_list_insert_delete_unit: FAILED **");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #20ms;
    $display("** indexed_list_insert_delete_unit: FAILED **");
    $finish;
  end

endmodule
